// ===== hdl/iir_direct_form_one_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the direct form I IIR filter
// Clocked on i_clk and held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IIRDF1_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IIRDF1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/iirdf1_pkg.sv =====
// ---------------------------------------------------------------------------
// iirdf1_pkg
// Shared widths, types, register indexes and reset values of the filter.
// ---------------------------------------------------------------------------
package iirdf1_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 40;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int NUM_FF_TAPS = 3;
    localparam int NUM_FB_TAPS = 2;
    localparam int ACC_W       = PROD_W + 3;
    localparam int FRAC_SHIFT  = 28;
    localparam int ORDER_W     = 2;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic        [ORDER_W-1:0]  t_order;

    typedef struct packed {
        logic advance;  // an item is transferred in this cycle
        logic preset;   // that item is a preset command
    } t_cell_ctl;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ORDER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_ORDER  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_GAIN    = 3'd7;

    // 1.0 in Q12.28
    localparam t_coef COEF_ONE = t_coef'(64'sd268435456);

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ===== hdl/iirdf1_ff_cell.sv =====
// ---------------------------------------------------------------------------
// iirdf1_ff_cell
// Input history cell: holds one past sample and forms its numerator product.
// ---------------------------------------------------------------------------
module iirdf1_ff_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iirdf1_pkg::t_cell_ctl i_ctl,
    input  iirdf1_pkg::t_sample  i_shift_in,
    input  iirdf1_pkg::t_sample  i_preset_val,
    input  iirdf1_pkg::t_coef    i_coef,
    input  logic                 i_tap_en,
    output iirdf1_pkg::t_sample  o_q,
    output iirdf1_pkg::t_prod    o_prod
);

    iirdf1_pkg::t_sample r_q;
    iirdf1_pkg::t_sample n_q;
    iirdf1_pkg::t_sample w_d;
    iirdf1_pkg::t_coef   w_coef;

    // value this tap takes with the item now being transferred
    assign w_d    = i_ctl.preset ? i_preset_val : i_shift_in;
    assign w_coef = i_tap_en ? i_coef : '0;
    assign o_prod = w_d * w_coef;

    assign n_q = i_ctl.advance ? w_d : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/iirdf1_fb_cell.sv =====
// ---------------------------------------------------------------------------
// iirdf1_fb_cell
// Output history cell: holds one past output and forms its feedback product.
// ---------------------------------------------------------------------------
module iirdf1_fb_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iirdf1_pkg::t_cell_ctl i_ctl,
    input  iirdf1_pkg::t_sample  i_shift_in,
    input  iirdf1_pkg::t_sample  i_preset_val,
    input  iirdf1_pkg::t_coef    i_coef,
    input  logic                 i_tap_en,
    output iirdf1_pkg::t_sample  o_q,
    output iirdf1_pkg::t_prod    o_prod
);

    iirdf1_pkg::t_sample r_q;
    iirdf1_pkg::t_sample n_q;
    iirdf1_pkg::t_coef   w_coef;

    // feedback uses the value held before this item
    assign w_coef = i_tap_en ? i_coef : '0;
    assign o_prod = r_q * w_coef;

    always_comb begin
        n_q = r_q;
        if (i_ctl.advance) begin
            n_q = i_ctl.preset ? i_preset_val : i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/iirdf1_sum.sv =====
// ---------------------------------------------------------------------------
// iirdf1_sum
// Adds the tap products, rounds Q28.44 to Q16.16 and saturates.
// ---------------------------------------------------------------------------
module iirdf1_sum (
    input  iirdf1_pkg::t_prod   i_ff_prod [iirdf1_pkg::NUM_FF_TAPS],
    input  iirdf1_pkg::t_prod   i_fb_prod [iirdf1_pkg::NUM_FB_TAPS],
    output iirdf1_pkg::t_sample o_result
);

    localparam int SHIFT_W = iirdf1_pkg::ACC_W - iirdf1_pkg::FRAC_SHIFT;
    localparam int HI_W    = SHIFT_W - iirdf1_pkg::SAMPLE_W + 1;
    localparam logic signed [iirdf1_pkg::ACC_W-1:0] ROUND_HALF =
        iirdf1_pkg::ACC_W'(64'sd1 << (iirdf1_pkg::FRAC_SHIFT - 1));

    logic signed [iirdf1_pkg::ACC_W-1:0] w_acc;
    logic signed [iirdf1_pkg::ACC_W-1:0] w_rnd;
    logic        [SHIFT_W-1:0]           w_shift;
    logic        [HI_W-1:0]              w_hi;

    always_comb begin
        w_acc = '0;
        for (int k = 0; k < iirdf1_pkg::NUM_FF_TAPS; k++) begin
            w_acc = w_acc + iirdf1_pkg::ACC_W'(i_ff_prod[k]);
        end
        for (int k = 0; k < iirdf1_pkg::NUM_FB_TAPS; k++) begin
            w_acc = w_acc - iirdf1_pkg::ACC_W'(i_fb_prod[k]);
        end
    end

    // round half up, then floor shift
    assign w_rnd   = w_acc + ROUND_HALF;
    assign w_shift = w_rnd[iirdf1_pkg::ACC_W-1:iirdf1_pkg::FRAC_SHIFT];
    assign w_hi    = w_shift[SHIFT_W-1:iirdf1_pkg::SAMPLE_W-1];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            o_result = w_shift[iirdf1_pkg::SAMPLE_W-1:0];
        end else if (w_hi[HI_W-1]) begin
            o_result = iirdf1_pkg::SAMPLE_MIN;
        end else begin
            o_result = iirdf1_pkg::SAMPLE_MAX;
        end
    end

endmodule

// ===== hdl/iir_direct_form_one_filter.sv =====
// ---------------------------------------------------------------------------
// iir_direct_form_one_filter: direct form I IIR filter, up to second order
// Each result is registered as its sample transfers in (skid entry if output stalled).
// One item per cycle while the skid entry is empty; the a1 feedback loop holds one register.
// Reset (sync, active low): histories zero, b0 and dc gain 1.0, rest zero.
// ---------------------------------------------------------------------------
`include "iir_direct_form_one_filter_assert.svh"

module iir_direct_form_one_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_wr_en,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]       i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] i_sample,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] o_filtered
);

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    iirdf1_pkg::t_coef  r_num_coef [iirdf1_pkg::NUM_FF_TAPS];
    iirdf1_pkg::t_coef  r_den_coef [iirdf1_pkg::NUM_FB_TAPS];
    iirdf1_pkg::t_order r_num_order;
    iirdf1_pkg::t_order r_den_order;
    iirdf1_pkg::t_coef  r_dc_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_coef[0] <= iirdf1_pkg::COEF_ONE;
            r_num_coef[1] <= '0;
            r_num_coef[2] <= '0;
            r_den_coef[0] <= '0;
            r_den_coef[1] <= '0;
            r_num_order   <= '0;
            r_den_order   <= '0;
            r_dc_gain     <= iirdf1_pkg::COEF_ONE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                iirdf1_pkg::CFG_NUM_COEF_0: r_num_coef[0] <= i_cfg_data;
                iirdf1_pkg::CFG_NUM_COEF_1: r_num_coef[1] <= i_cfg_data;
                iirdf1_pkg::CFG_NUM_COEF_2: r_num_coef[2] <= i_cfg_data;
                iirdf1_pkg::CFG_DEN_COEF_1: r_den_coef[0] <= i_cfg_data;
                iirdf1_pkg::CFG_DEN_COEF_2: r_den_coef[1] <= i_cfg_data;
                iirdf1_pkg::CFG_NUM_ORDER:  r_num_order   <= i_cfg_data[iirdf1_pkg::ORDER_W-1:0];
                iirdf1_pkg::CFG_DEN_ORDER:  r_den_order   <= i_cfg_data[iirdf1_pkg::ORDER_W-1:0];
                iirdf1_pkg::CFG_DC_GAIN:    r_dc_gain     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Handshake: an output register plus one skid entry. The input side
    // stalls only while the skid entry is full, so a new transfer is taken
    // while a finished result still waits downstream.
    // -----------------------------------------------------------------------
    logic                r_out_valid;
    logic                n_out_valid;
    iirdf1_pkg::t_sample r_out_data;
    iirdf1_pkg::t_sample n_out_data;
    logic                r_skid_valid;
    logic                n_skid_valid;
    iirdf1_pkg::t_sample r_skid_data;
    iirdf1_pkg::t_sample n_skid_data;

    logic                w_in_xfer;
    logic                w_out_xfer;
    iirdf1_pkg::t_sample w_result;
    iirdf1_pkg::t_cell_ctl w_ctl;

    assign w_in_xfer  = i_in_valid && !r_skid_valid;
    assign w_out_xfer = r_out_valid && !i_out_stall;

    assign w_ctl.advance = w_in_xfer;
    assign w_ctl.preset  = i_command;

    // -----------------------------------------------------------------------
    // Tap enables. An order of three acts as two. On a preset only tap zero
    // contributes, and it uses the dc gain in place of b0.
    // -----------------------------------------------------------------------
    iirdf1_pkg::t_coef w_ff_coef [iirdf1_pkg::NUM_FF_TAPS];
    logic              w_ff_en   [iirdf1_pkg::NUM_FF_TAPS];
    logic              w_fb_en   [iirdf1_pkg::NUM_FB_TAPS];

    always_comb begin
        w_ff_coef[0] = i_command ? r_dc_gain : r_num_coef[0];
        w_ff_coef[1] = r_num_coef[1];
        w_ff_coef[2] = r_num_coef[2];
        w_ff_en[0]   = 1'b1;
        w_ff_en[1]   = !i_command && (|r_num_order);
        w_ff_en[2]   = !i_command && r_num_order[1];
        w_fb_en[0]   = !i_command && (|r_den_order);
        w_fb_en[1]   = !i_command && r_den_order[1];
    end

    // -----------------------------------------------------------------------
    // Cell chains: input history cells shift the new sample along, output
    // history cells shift the new result along. Every cell forms its product.
    // -----------------------------------------------------------------------
    iirdf1_pkg::t_sample w_ff_q    [iirdf1_pkg::NUM_FF_TAPS];
    iirdf1_pkg::t_prod   w_ff_prod [iirdf1_pkg::NUM_FF_TAPS];
    iirdf1_pkg::t_sample w_fb_q    [iirdf1_pkg::NUM_FB_TAPS];
    iirdf1_pkg::t_prod   w_fb_prod [iirdf1_pkg::NUM_FB_TAPS];

    for (genvar k = 0; k < iirdf1_pkg::NUM_FF_TAPS; k++) begin : g_ff
        iirdf1_pkg::t_sample w_link;
        if (k == 0) begin : g_head
            assign w_link = i_sample;
        end else begin : g_body
            assign w_link = w_ff_q[k-1];
        end
        iirdf1_ff_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_shift_in   (w_link),
            .i_preset_val (i_sample),
            .i_coef       (w_ff_coef[k]),
            .i_tap_en     (w_ff_en[k]),
            .o_q          (w_ff_q[k]),
            .o_prod       (w_ff_prod[k])
        );
    end

    for (genvar k = 0; k < iirdf1_pkg::NUM_FB_TAPS; k++) begin : g_fb
        iirdf1_pkg::t_sample w_link;
        if (k == 0) begin : g_head
            assign w_link = w_result;
        end else begin : g_body
            assign w_link = w_fb_q[k-1];
        end
        iirdf1_fb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_shift_in   (w_link),
            .i_preset_val (w_result),
            .i_coef       (r_den_coef[k]),
            .i_tap_en     (w_fb_en[k]),
            .o_q          (w_fb_q[k]),
            .o_prod       (w_fb_prod[k])
        );
    end

    iirdf1_sum u_sum (
        .i_ff_prod (w_ff_prod),
        .i_fb_prod (w_fb_prod),
        .o_result  (w_result)
    );

    // -----------------------------------------------------------------------
    // Output register and skid entry
    // -----------------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_out_xfer || !r_out_valid) begin
            // output register is free: drain the skid entry first
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_in_xfer;
                n_out_data  = w_result;
            end
        end else if (w_in_xfer) begin
            // output held by a stall: park the new result
            n_skid_valid = 1'b1;
            n_skid_data  = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out_data;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `IIRDF1_ASSERT_SAME(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `IIRDF1_ASSERT_NEXT(a_xfer_gives_out, w_in_xfer, r_out_valid, "transfer left no result")
    `IIRDF1_ASSERT_NEXT(a_stall_parks, w_in_xfer && r_out_valid && i_out_stall, r_skid_valid, "result not parked")
    `IIRDF1_ASSERT_NEXT(a_preset_fills, w_in_xfer && i_command, (w_ff_q[0] == w_ff_q[2]) && (w_fb_q[0] == w_fb_q[1]), "preset left histories uneven")

endmodule

// ===== verif/iir_direct_form_one_filter_tb.sv =====
// ---------------------------------------------------------------------------
// iir_direct_form_one_filter_tb: self-checking bench for the biquad filter
// Drives filter and preset commands through the valid/stall channels, runs a
// fixed-point copy of the filter alongside the block and compares every
// output transfer with its prediction. Registers are rewritten between
// phases while the block is idle. Sender bursts, receiver stall patterns and
// one long receiver hold-off put gaps and back-pressure on the channels.
// ---------------------------------------------------------------------------
module iir_direct_form_one_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iirdf1_pkg::*;

    localparam int    MAX_ORDER    = NUM_FB_TAPS;
    localparam logic  CMD_FILTER   = 1'b0;
    localparam logic  CMD_PRESET   = 1'b1;
    localparam t_coef COEF_MAX     = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef COEF_MIN     = {1'b1, {(COEF_W-1){1'b0}}};
    localparam int    HOLDOFF_LEN  = 300;
    localparam int    MAX_REPORTS  = 30;

    // wide enough for the exact sum of all five Q28.44 products
    typedef logic signed [79:0] t_acc;
    localparam t_acc ROUND_HALF = t_acc'(1) <<< (FRAC_SHIFT - 1);

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [COEF_W-1:0]          i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_command;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_filtered;

    // filter state and configuration as the bench sees it
    t_coef   coef_b [3];
    t_coef   coef_a [1:2];
    t_order  ord_num;
    t_order  ord_den;
    t_coef   gain_dc;
    t_sample hist_in [3];
    t_sample hist_out [2];

    // outputs still owed by the block, oldest first
    t_sample pending_outputs [$];
    t_sample exp_y;
    int      mismatch_count = 0;

    // sender burst control
    int unsigned burst_left = 0;
    bit          sender_gaps_on = 1'b1;

    // receiver stall control
    bit          holdoff_req = 1'b0;
    bit          holdoff_ack = 1'b0;
    int unsigned holdoff_left = 0;
    int unsigned mode_left = 0;
    int unsigned cycle_cnt = 0;
    t_stall_mode stall_mode = STALL_NONE;

    iir_direct_form_one_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Fixed-point filter prediction
    // -----------------------------------------------------------------------

    // Exact signed product of a Q16.16 sample and a Q12.28 coefficient.
    function automatic t_acc tap_product(input t_sample s, input t_coef c);
        t_acc sx;
        t_acc cx;
        sx = s;
        cx = c;
        return sx * cx;
    endfunction

    // Round Q28.44 to Q16.16 (half toward plus infinity), then clamp.
    function automatic t_sample round_sat(input t_acc acc);
        t_acc q;
        q = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        if (q > t_acc'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (q < t_acc'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return t_sample'(q);
    endfunction

    function automatic void reset_filter_state();
        coef_b   = '{COEF_ONE, '0, '0};
        coef_a   = '{'0, '0};
        ord_num  = '0;
        ord_den  = '0;
        gain_dc  = COEF_ONE;
        hist_in  = '{'0, '0, '0};
        hist_out = '{'0, '0};
    endfunction

    // Advance the filter state by one command and return its output.
    function automatic t_sample predict_filter_output(input logic cmd, input t_sample smp);
        t_acc    acc;
        t_sample y;
        int      nb;
        int      na;
        acc = '0;
        // an order above the filter's maximum behaves as the maximum
        nb = (ord_num > MAX_ORDER) ? MAX_ORDER : int'(ord_num);
        na = (ord_den > MAX_ORDER) ? MAX_ORDER : int'(ord_den);
        if (cmd == CMD_PRESET) begin
            // fill every history entry, whatever the orders
            y        = round_sat(tap_product(smp, gain_dc));
            hist_in  = '{smp, smp, smp};
            hist_out = '{y, y};
        end else begin
            // all entries shift; unused taps only drop out of the sum
            hist_in[2] = hist_in[1];
            hist_in[1] = hist_in[0];
            hist_in[0] = smp;
            for (int k = 0; k <= nb; k++)
                acc += tap_product(hist_in[k], coef_b[k]);
            for (int k = 1; k <= na; k++)
                acc -= tap_product(hist_out[k-1], coef_a[k]);
            y           = round_sat(acc);
            hist_out[1] = hist_out[0];
            hist_out[0] = y;
        end
        return y;
    endfunction

    // -----------------------------------------------------------------------
    // Random value pickers
    // -----------------------------------------------------------------------

    function automatic t_coef pick_coef();
        logic [63:0] raw;
        int unsigned r;
        raw = {$urandom, $urandom};
        r   = $urandom_range(0, 9);
        // mostly gains within +/-1.0 so the filter stays in range
        if (r < 6)
            return {{(COEF_W-29){raw[28]}}, raw[28:0]};
        if (r < 8)
            return raw[COEF_W-1:0];
        return (r == 8) ? COEF_MAX : COEF_MIN;
    endfunction

    function automatic t_sample pick_sample();
        logic [31:0] raw;
        int unsigned r;
        raw = $urandom;
        r   = $urandom_range(0, 9);
        if (r < 4)
            return raw;
        if (r < 8)
            return {{12{raw[19]}}, raw[19:0]};
        if (r == 8)
            return raw[0] ? SAMPLE_MAX : SAMPLE_MIN;
        return {{31{raw[1]}}, raw[0]};
    endfunction

    function automatic logic pick_command();
        return ($urandom_range(0, 19) == 0) ? CMD_PRESET : CMD_FILTER;
    endfunction

    // -----------------------------------------------------------------------
    // Channel and register drivers
    // -----------------------------------------------------------------------

    // Offer one command; return at the edge that transfers it.
    task automatic send_item(input logic cmd, input t_sample smp);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if (sender_gaps_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3);
        end
        burst_left--;
        if (gap != 0) begin
            // drop valid and scribble the payload while idle
            i_in_valid <= 1'b0;
            i_command  <= 1'($urandom_range(0, 1));
            i_sample   <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_sample   <= smp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_outputs.push_back(predict_filter_output(cmd, smp));
    endtask

    // Hold the sender until every owed output has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (pending_outputs.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Drain the block, then rewrite all eight registers.
    task automatic program_filter(input t_coef b0, input t_coef b1, input t_coef b2,
                                  input t_coef a1, input t_coef a2,
                                  input t_order nord, input t_order dord, input t_coef gain);
        wait_idle();
        write_reg(CFG_NUM_COEF_0, b0);
        write_reg(CFG_NUM_COEF_1, b1);
        write_reg(CFG_NUM_COEF_2, b2);
        write_reg(CFG_DEN_COEF_1, a1);
        write_reg(CFG_DEN_COEF_2, a2);
        write_reg(CFG_NUM_ORDER, {{(COEF_W-ORDER_W){1'b0}}, nord});
        write_reg(CFG_DEN_ORDER, {{(COEF_W-ORDER_W){1'b0}}, dord});
        write_reg(CFG_DC_GAIN, gain);
        i_cfg_wr_en <= 1'b0;
        coef_b    = '{b0, b1, b2};
        coef_a[1] = a1;
        coef_a[2] = a2;
        ord_num   = nord;
        ord_den   = dord;
        gain_dc   = gain;
    endtask

    task automatic program_random();
        program_filter(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                       t_order'($urandom_range(0, 3)), t_order'($urandom_range(0, 3)),
                       pick_coef());
    endtask

    // -----------------------------------------------------------------------
    // Receiver: stall patterns, plus a long hold-off on request
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (holdoff_req != holdoff_ack) begin
            holdoff_ack  = holdoff_req;
            holdoff_left = HOLDOFF_LEN;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 160);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 1) == 0);
                STALL_PERIODIC: i_out_stall <= ((cycle_cnt % 5) < 2);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Output checker: each transfer against the oldest prediction
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("output %h with nothing owed", o_filtered));
            end else begin
                exp_y = pending_outputs.pop_front();
                if (o_filtered !== exp_y)
                    report_mismatch($sformatf("filtered %h, expected %h", o_filtered, exp_y));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset values: b0 = 1.0 with order 0 passes samples through, gain 1.0.
    task automatic test_reset_defaults();
        send_item(CMD_FILTER, SAMPLE_MAX);
        send_item(CMD_FILTER, SAMPLE_MIN);
        send_item(CMD_FILTER, -32'sd1);
        send_item(CMD_FILTER, 32'sh0001_8000);
        send_item(CMD_PRESET, 32'sh0003_0000);
    endtask

    // Clamp at both rails and round-half-up at one LSB of gain.
    task automatic test_saturation_rounding();
        program_filter(COEF_MAX, '0, '0, '0, '0, 2'd0, 2'd0, COEF_MAX);
        send_item(CMD_FILTER, SAMPLE_MAX);
        send_item(CMD_FILTER, SAMPLE_MIN);
        send_item(CMD_PRESET, SAMPLE_MAX);
        program_filter(COEF_MIN, '0, '0, '0, '0, 2'd0, 2'd0, COEF_MIN);
        send_item(CMD_FILTER, SAMPLE_MIN);
        send_item(CMD_PRESET, 32'sd1);
        program_filter(t_coef'(1), '0, '0, '0, '0, 2'd0, 2'd0, t_coef'(1));
        send_item(CMD_FILTER, 32'sd134217728);
        send_item(CMD_FILTER, -32'sd134217728);
        send_item(CMD_FILTER, -32'sd402653184);
        send_item(CMD_PRESET, 32'sd402653184);
    endtask

    // Orders above the maximum, partial orders, and taps that keep shifting.
    task automatic test_order_taps();
        program_filter(t_coef'(64'sd134217728), t_coef'(64'sd67108864),
                       t_coef'(-64'sd33554432), t_coef'(-64'sd134217728),
                       t_coef'(64'sd67108864), 2'd3, 2'd3, t_coef'(64'sd536870912));
        send_item(CMD_PRESET, 32'sh0001_0000);
        send_item(CMD_FILTER, 32'sh0002_0000);
        send_item(CMD_FILTER, -32'sh0000_8000);
        send_item(CMD_FILTER, 32'sh7fff_0000);
        program_filter(coef_b[0], coef_b[1], coef_b[2], coef_a[1], coef_a[2],
                       2'd0, 2'd2, gain_dc);
        send_item(CMD_FILTER, 32'sh0004_0000);
        send_item(CMD_FILTER, 32'sh0000_0001);
        program_filter(coef_b[0], coef_b[1], coef_b[2], coef_a[1], coef_a[2],
                       2'd2, 2'd0, gain_dc);
        send_item(CMD_FILTER, -32'sh0003_0000);
        send_item(CMD_FILTER, 32'sh0001_2345);
        program_filter(coef_b[0], coef_b[1], coef_b[2], coef_a[1], coef_a[2],
                       2'd1, 2'd1, gain_dc);
        send_item(CMD_FILTER, 32'sh0010_0000);
        send_item(CMD_FILTER, -32'sh0000_0001);
    endtask

    // Long receiver hold-off under a gapless sender, then a full drain pause.
    task automatic test_backpressure();
        program_random();
        sender_gaps_on = 1'b0;
        holdoff_req    = ~holdoff_req;
        for (int n = 0; n < 40; n++)
            send_item(pick_command(), pick_sample());
        sender_gaps_on = 1'b1;
        wait_idle();
        for (int n = 0; n < 40; n++)
            send_item(pick_command(), pick_sample());
    endtask

    // Phases of random traffic, each under its own register setting.
    task automatic test_random_phases();
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                                  2'd2, 2'd2, COEF_MAX);
                1: program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                                  2'd3, 2'd3, COEF_MIN);
                2: program_filter('0, '0, '0, '0, '0, 2'd2, 2'd1, '0);
                default: program_random();
            endcase
            for (int n = 0; n < ((ph < 3) ? 40 : 215); n++) begin
                send_item(pick_command(), pick_sample());
                // pause mid-phase now and then until all outputs are back
                if (n == 100 && ph[0])
                    wait_idle();
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_command   <= CMD_FILTER;
        i_sample    <= '0;
        i_out_stall <= 1'b0;
        reset_filter_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation_rounding();
        test_order_taps();
        test_backpressure();
        test_random_phases();

        // drain, then leave room for any stray output
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("iir_direct_form_one_filter_tb: clean");
        else
            $display("iir_direct_form_one_filter_tb: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("iir_direct_form_one_filter_tb: errors");
        $finish;
    end

endmodule
